FILE: design/lqs_pkg.sv
package lqs_pkg;

    localparam int SAMPLE_CAPACITY = 512;
    localparam int ADDR_W  = $clog2(SAMPLE_CAPACITY);
    localparam int CNT_W   = $clog2(SAMPLE_CAPACITY + 1);
    localparam int SAMPLE_W = 32;
    localparam int FIX_W   = 40;
    localparam int SUM_W   = SAMPLE_W + CNT_W;
    localparam int NUM_W   = 2 * FIX_W + 1;
    localparam int DEN_W   = FIX_W + 1;
    localparam int MUL_SPLIT = FIX_W / 2;
    localparam logic [FIX_W-1:0] LIMIT_RESET = '1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLOSE  = 1'b1;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample_value;
        logic [SAMPLE_W-1:0] window_min;
        logic [SAMPLE_W-1:0] window_max;
        logic                erase_totals;
    } t_in;

    typedef struct packed {
        logic                kind;
        logic [FIX_W-1:0]    avg_value;
        logic [FIX_W-1:0]    mid_value;
        logic [FIX_W-1:0]    lower_q;
        logic [FIX_W-1:0]    upper_q;
        logic [SAMPLE_W-1:0] least;
        logic [SAMPLE_W-1:0] greatest;
        logic [FIX_W-1:0]    count;
        logic                overflow;
        logic                last;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OUTER_RD,
        ST_OUTER_WAIT,
        ST_INNER_RD,
        ST_INNER_WAIT,
        ST_INNER_CMP,
        ST_INSERT,
        ST_SUM_RD,
        ST_SUM_WAIT,
        ST_SUM_ACC,
        ST_AVG_DIV,
        ST_AVG_WAIT,
        ST_Q_RD,
        ST_Q_WAIT,
        ST_Q_TAKE,
        ST_MUL_A,
        ST_MUL_B,
        ST_BL_DIV,
        ST_BL_WAIT,
        ST_UPDATE,
        ST_OUT0,
        ST_OUT1
    } t_state;

endpackage

FILE: design/lqs_ram.sv
module lqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/lqs_div.sv
module lqs_div
    import lqs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    // restoring divider, one quotient bit per cycle
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_num, n_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    r_rem, n_rem;
    logic [STEP_W-1:0] r_step;
    logic              r_busy, r_done;
    logic [DEN_W:0]    w_shift;

    always_comb begin
        w_shift = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
        n_num   = {r_num[NUM_W-2:0], 1'b0};
        n_rem   = w_shift;
        if (w_shift >= {1'b0, r_den}) begin
            n_rem    = w_shift - {1'b0, r_den};
            n_num[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divider restarted while busy");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
endmodule

FILE: design/latency_quartile_stats.sv
// Latency period and cumulative statistics.
// Command port: i_in is taken when i_start is high and o_busy low. A sample
// transaction (op 0) is written to a 512-entry store and o_busy never
// rises; samples past the capacity are dropped.
// A close transaction (op 1) holds o_busy while the store is insertion sorted
// through its single read port, then summed, then the mean is taken with
// the shared 81-step divider; the three quantiles are then read from the
// sorted store and, unless the totals are empty or the limit is reached,
// the four totals (mean and quantiles) are blended via the same divider in
// turn. Two records follow on o_out, each valid for one cycle with o_valid:
// period record then cumulative record (last set). The receiver cannot
// stall them. The overflow limit register r_limit is written from i_cfg_data
// when i_cfg_we is high; the user must write it only while idle, as the block
// does not enforce this. Reset (i_rst_n low, synchronous) empties the store,
// clears all totals and sets the overflow limit to all ones.
module latency_quartile_stats
    import lqs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_in              i_in,
    output logic             o_busy,
    input  logic             i_cfg_we,
    input  logic [FIX_W-1:0] i_cfg_data,
    output logic             o_valid,
    output t_out             o_out
);
    t_state r_state, n_state;

    logic [FIX_W-1:0]    r_limit;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_i, n_i;
    logic [CNT_W-1:0]    r_j, n_j;
    logic [SAMPLE_W-1:0] r_v, n_v;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [1:0]          r_k, n_k;
    logic [FIX_W-1:0]    r_tot [4];
    logic [FIX_W-1:0]    r_per [4];
    logic [SAMPLE_W-1:0] r_tleast, r_tgreat, r_wmin, r_wmax;
    logic [FIX_W-1:0]    r_tcnt;
    logic                r_erase, r_ovf;
    logic [NUM_W-1:0]    r_prod, r_acc;

    logic                  w_we;
    logic [ADDR_W-1:0]     w_waddr, w_raddr;
    logic [SAMPLE_W-1:0]   w_wdata, w_rdata;
    t_div_req              w_dreq;
    t_div_rsp              w_drsp;
    logic [CNT_W-1:0]      w_up, w_qidx;
    logic [FIX_W:0]        w_newcnt;

    lqs_ram #(.WIDTH(SAMPLE_W), .DEPTH(SAMPLE_CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    lqs_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign w_up = (r_cnt - (r_cnt >> 2) > r_cnt - 1'b1) ? r_cnt - 1'b1
                                                         : r_cnt - (r_cnt >> 2);
    // one bit wider so the limit compare cannot wrap
    assign w_newcnt = {1'b0, r_tcnt} + (FIX_W+1)'(r_cnt);

    always_comb begin
        case (r_k)
            2'd1:    w_qidx = r_cnt >> 1;
            2'd2:    w_qidx = r_cnt >> 2;
            default: w_qidx = w_up;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_i = r_i; n_j = r_j; n_v = r_v; n_sum = r_sum; n_k = r_k;
        w_we = 1'b0; w_waddr = r_j[ADDR_W-1:0]; w_wdata = w_rdata;
        w_raddr = r_i[ADDR_W-1:0];
        w_dreq = '0;
        w_dreq.num = r_acc;
        w_dreq.den = DEN_W'(w_newcnt);
        case (r_state)
            ST_IDLE: begin
                w_waddr = r_cnt[ADDR_W-1:0];
                w_wdata = i_in.sample_value;
                if (i_start && i_in.op == OP_SAMPLE
                        && r_cnt < CNT_W'(SAMPLE_CAPACITY)) begin
                    w_we = 1'b1;
                end
                if (i_start && i_in.op == OP_CLOSE) begin
                    n_i = CNT_W'(1);
                    n_state = (r_cnt == '0) ? ST_OUT0 : ST_OUTER_RD;
                end
            end
            ST_OUTER_RD: begin
                if (r_i >= r_cnt) begin
                    n_i = '0; n_sum = '0;
                    n_state = ST_SUM_RD;
                end else begin
                    n_state = ST_OUTER_WAIT;
                end
            end
            ST_OUTER_WAIT: begin
                n_state = ST_INNER_RD;
                n_j = r_i;
            end
            ST_INNER_RD: begin
                if (r_state == ST_INNER_RD && r_j == r_i) n_v = w_rdata;
                if (r_j == '0) begin
                    n_state = ST_INSERT;
                end else begin
                    n_state = ST_INNER_WAIT;
                end
            end
            ST_INNER_WAIT: begin
                w_raddr = ADDR_W'(r_j - 1'b1);
                n_state = ST_INNER_CMP;
            end
            ST_INNER_CMP: begin
                w_raddr = ADDR_W'(r_j - 1'b1);
                if (w_rdata > r_v) begin
                    w_we = 1'b1;
                    w_wdata = w_rdata;
                    n_j = r_j - 1'b1;
                    n_state = (r_j == CNT_W'(1)) ? ST_INSERT : ST_INNER_WAIT;
                end else begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                w_we = 1'b1;
                w_wdata = r_v;
                n_i = r_i + 1'b1;
                n_state = ST_OUTER_RD;
            end
            ST_SUM_RD: begin
                n_state = ST_SUM_WAIT;
            end
            ST_SUM_WAIT: begin
                n_state = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                n_sum = r_sum + SUM_W'(w_rdata);
                n_i = r_i + 1'b1;
                n_state = (r_i + 1'b1 >= r_cnt) ? ST_AVG_DIV : ST_SUM_RD;
            end
            ST_AVG_DIV: begin
                w_dreq.start = 1'b1;
                w_dreq.num = NUM_W'(r_sum);
                w_dreq.den = DEN_W'(r_cnt);
                n_state = ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                if (w_drsp.done) begin
                    n_k = 2'd1;
                    n_state = ST_Q_RD;
                end
            end
            ST_Q_RD: begin
                w_raddr = w_qidx[ADDR_W-1:0];
                n_state = ST_Q_WAIT;
            end
            ST_Q_WAIT: begin
                w_raddr = w_qidx[ADDR_W-1:0];
                n_state = ST_Q_TAKE;
            end
            ST_Q_TAKE: begin
                n_k = r_k + 1'b1;
                if (r_k == 2'd3) begin
                    n_k = 2'd0;
                    n_state = (w_newcnt >= {1'b0, r_limit} || r_tcnt == '0) ? ST_UPDATE
                                                                            : ST_MUL_A;
                end else begin
                    n_state = ST_Q_RD;
                end
            end
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_BL_DIV;
            ST_BL_DIV: begin
                w_dreq.start = 1'b1;
                n_state = ST_BL_WAIT;
            end
            ST_BL_WAIT: begin
                if (w_drsp.done) begin
                    n_k = r_k + 1'b1;
                    n_state = (r_k == 2'd3) ? ST_UPDATE : ST_MUL_A;
                end
            end
            ST_UPDATE: n_state = ST_OUT0;
            ST_OUT0:   n_state = ST_OUT1;
            ST_OUT1:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_limit <= LIMIT_RESET;
            r_cnt <= '0;
            r_tcnt <= '0;
            r_tleast <= '0;
            r_tgreat <= '0;
            r_ovf <= 1'b0;
            for (int q = 0; q < 4; q++) r_tot[q] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (r_state == ST_IDLE && i_start) begin
                if (i_in.op == OP_SAMPLE && r_cnt < CNT_W'(SAMPLE_CAPACITY))
                    r_cnt <= r_cnt + 1'b1;
                if (i_in.op == OP_CLOSE) r_ovf <= 1'b0;
            end
            if (r_state == ST_BL_WAIT && w_drsp.done)
                r_tot[r_k] <= w_drsp.quo[FIX_W-1:0];
            if (r_state == ST_UPDATE) begin
                if (w_newcnt >= {1'b0, r_limit}) begin
                    r_ovf <= 1'b1;
                end else begin
                    if (r_tcnt == '0)
                        for (int q = 0; q < 4; q++) r_tot[q] <= r_per[q];
                    r_tcnt <= w_newcnt[FIX_W-1:0];
                    if (r_wmax > r_tgreat) r_tgreat <= r_wmax;
                    if (r_wmin != '0 && (r_tleast == '0 || r_wmin < r_tleast))
                        r_tleast <= r_wmin;
                end
            end
            if (r_state == ST_OUT1) begin
                r_cnt <= '0;
                if (r_ovf || r_erase) begin
                    for (int q = 0; q < 4; q++) r_tot[q] <= '0;
                    r_tcnt <= '0;
                    r_tleast <= '0;
                    r_tgreat <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_v <= n_v; r_sum <= n_sum; r_k <= n_k;
        if (r_state == ST_IDLE && i_start && i_in.op == OP_CLOSE) begin
            r_wmin <= i_in.window_min;
            r_wmax <= i_in.window_max;
            r_erase <= i_in.erase_totals;
            for (int q = 0; q < 4; q++) r_per[q] <= '0;
        end
        if (r_state == ST_AVG_WAIT && w_drsp.done)
            r_per[0] <= {w_drsp.quo[SAMPLE_W-1:0], 8'd0};
        if (r_state == ST_Q_TAKE) r_per[r_k] <= {w_rdata, 8'd0};
        // total*count built from two 40x20 products, low half first
        if (r_state == ST_MUL_A)
            r_prod <= NUM_W'(r_tot[r_k] * r_tcnt[MUL_SPLIT-1:0])
                    + NUM_W'(r_per[r_k] * r_cnt);
        if (r_state == ST_MUL_B)
            r_acc <= r_prod
                   + (NUM_W'(r_tot[r_k] * r_tcnt[FIX_W-1:MUL_SPLIT]) << MUL_SPLIT);
    end

    always_comb begin
        o_busy  = (r_state != ST_IDLE);
        o_valid = (r_state == ST_OUT0) || (r_state == ST_OUT1);
        o_out   = '0;
        if (r_state == ST_OUT0) begin
            o_out.avg_value = r_per[0];
            o_out.mid_value = r_per[1];
            o_out.lower_q   = r_per[2];
            o_out.upper_q   = r_per[3];
            o_out.least     = r_wmin;
            o_out.greatest  = r_wmax;
            o_out.count     = FIX_W'(r_cnt);
        end else begin
            o_out.kind      = 1'b1;
            o_out.last      = 1'b1;
            o_out.avg_value = r_tot[0];
            o_out.mid_value = r_tot[1];
            o_out.lower_q   = r_tot[2];
            o_out.upper_q   = r_tot[3];
            o_out.least     = r_tleast;
            o_out.greatest  = r_tgreat;
            o_out.count     = r_tcnt;
        end
        o_out.overflow = r_ovf;
    end

    a_out_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT0) |=> (r_state == ST_OUT1)) else $error("record pair split");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(SAMPLE_CAPACITY)) else $error("store count past capacity");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT1) |=> (r_cnt == '0)) else $error("store not emptied");
endmodule
